/* hw/rtl/lsbc_pkg.sv */
// ----------------------------------------------------------------------------
// lsbc_pkg: shared types and constants for the scan breakpoint clusterer
// Holds widths, register indexes, the controller states, and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lsbc_pkg;

    localparam int SCAN_POINTS = 2048;
    localparam int IDX_W       = $clog2(SCAN_POINTS);
    localparam int RANGE_BITS  = 16;
    localparam int CNT_W       = 12;
    localparam int RF_W        = 22;
    localparam int COS_W       = 17;
    localparam int MARGIN_W    = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = 22;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int RES_DEPTH   = 3;
    localparam int RES_PTR_W   = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_FACTOR     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COS_STEP         = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_MARGIN     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OCCLUSION_MARGIN = 8'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WRAP,
        ST_M_AA,
        ST_M_BB,
        ST_M_AB,
        ST_M_ABC,
        ST_M_AR,
        ST_M_D,
        ST_M_DHH,
        ST_M_DHL,
        ST_M_DLL,
        ST_M_SUM,
        ST_M_CMP,
        ST_APPLY,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AA,
        MUL_BB,
        MUL_AB,
        MUL_ABC,
        MUL_AR,
        MUL_D,
        MUL_DHH,
        MUL_DHL,
        MUL_DLL,
        MUL_SUM,
        MUL_CMP
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    init_pt;
        logic    sel_wrap;
        logic    apply;
        logic    finish;
        logic    pop;
        mul_op_t mul_op;
    } lsbc_cmd_t;

    typedef struct packed {
        logic pt_valid;
        logic have_valid;
        logic pair_seen;
        logic last;
        logic dyn_pair0;
        logic dyn_wrap;
        logic sel_wrap;
        logic res_any;
        logic out_last;
    } lsbc_status_t;

    typedef struct packed {
        logic             occ;
        logic [CNT_W-1:0] count;
        logic [10:0]      end_idx;
        logic [10:0]      start_idx;
    } lsbc_res_t;

endpackage

/* hw/rtl/lsbc_ctrl.sv */
// ----------------------------------------------------------------------------
// lsbc_ctrl: sequencer for the scan breakpoint clusterer
// Walks one word through point check, optional breakpoint multiply sequence,
// pair update, wrap pair, scan finish and result delivery.
// ----------------------------------------------------------------------------
module lsbc_ctrl import lsbc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  lsbc_status_t status,
    output lsbc_cmd_t    cmd
);

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (!status.pt_valid || !status.have_valid) state_next = ST_WRAP;
                else if (status.dyn_pair0) state_next = ST_M_AA;
                else state_next = ST_APPLY;
            end
            ST_WRAP: begin
                if (status.last && status.have_valid && status.pair_seen) begin
                    state_next = status.dyn_wrap ? ST_M_AA : ST_APPLY;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_M_AA:  state_next = ST_M_BB;
            ST_M_BB:  state_next = ST_M_AB;
            ST_M_AB:  state_next = ST_M_ABC;
            ST_M_ABC: state_next = ST_M_AR;
            ST_M_AR:  state_next = ST_M_D;
            ST_M_D:   state_next = ST_M_DHH;
            ST_M_DHH: state_next = ST_M_DHL;
            ST_M_DHL: state_next = ST_M_DLL;
            ST_M_DLL: state_next = ST_M_SUM;
            ST_M_SUM: state_next = ST_M_CMP;
            ST_M_CMP: state_next = ST_APPLY;
            ST_APPLY: state_next = status.sel_wrap ? ST_FIN : ST_WRAP;
            ST_FIN:   state_next = status.res_any ? ST_OUT : ST_IDLE;
            ST_OUT: begin
                if (m_ready && status.out_last) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CHECK: begin
                cmd.init_pt = status.pt_valid && !status.have_valid;
            end
            ST_WRAP: begin
                cmd.sel_wrap = status.last && status.have_valid && status.pair_seen;
            end
            ST_M_AA:  cmd.mul_op = MUL_AA;
            ST_M_BB:  cmd.mul_op = MUL_BB;
            ST_M_AB:  cmd.mul_op = MUL_AB;
            ST_M_ABC: cmd.mul_op = MUL_ABC;
            ST_M_AR:  cmd.mul_op = MUL_AR;
            ST_M_D:   cmd.mul_op = MUL_D;
            ST_M_DHH: cmd.mul_op = MUL_DHH;
            ST_M_DHL: cmd.mul_op = MUL_DHL;
            ST_M_DLL: cmd.mul_op = MUL_DLL;
            ST_M_SUM: cmd.mul_op = MUL_SUM;
            ST_M_CMP: cmd.mul_op = MUL_CMP;
            ST_APPLY: cmd.apply = 1'b1;
            ST_FIN:   cmd.finish = 1'b1;
            ST_OUT: begin
                m_valid = 1'b1;
                cmd.pop = m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/lsbc_dp.sv */
// ----------------------------------------------------------------------------
// lsbc_dp: datapath of the scan breakpoint clusterer
// Holds configuration, scan state, the shared 32x22 multiplier with its
// accumulators for the breakpoint test, the pair update and a result buffer.
// ----------------------------------------------------------------------------
module lsbc_dp import lsbc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [RANGE_BITS-1:0] in_dyn,
    input  logic [RANGE_BITS-1:0] in_raw,
    input  logic                  in_last,
    input  lsbc_cmd_t             cmd,
    output lsbc_status_t          status,
    output lsbc_res_t             out_res
);

    // Configuration
    logic [RF_W-1:0]     range_factor_reg;
    logic [COS_W-1:0]    cos_step_reg;
    logic [MARGIN_W-1:0] noise_margin_reg;
    logic [MARGIN_W-1:0] occ_margin_reg;

    // Captured word and scan state
    logic [RANGE_BITS-1:0] cur_dyn_reg, cur_raw_reg;
    logic                  cur_last_reg;
    logic [IDX_W-1:0]      cur_idx_reg;
    logic [IDX_W-1:0]      sample_index_reg;
    logic                  have_valid_reg, pair_seen_reg, sel_wrap_reg, sof_reg;
    logic [RANGE_BITS-1:0] prev_dyn_reg, prev_raw_reg, first_dyn_reg, first_raw_reg;
    logic [IDX_W-1:0]      prev_idx_reg;
    logic [IDX_W-1:0]      h_start_reg, h_end_reg, t_start_reg;
    logic [CNT_W-1:0]      h_count_reg, t_count_reg;
    logic                  h_fin_reg, h_occ_reg;

    // Breakpoint arithmetic
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p, prod_reg;
    logic [32:0]        sum_reg;
    logic [49:0]        d2_reg;
    logic [38:0]        d_reg;
    logic [66:0]        q_reg;
    logic               big_reg, within_reg;
    logic [49:0]        s_val, p_val;
    logic [16:0]        dh;
    logic [15:0]        dl;

    // Result buffer
    lsbc_res_t             res_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]  res_cnt_reg, res_rd_reg;

    // Pair update signals
    logic [RANGE_BITS-1:0] nxt_dyn, nxt_raw;
    logic                  cs, ns, far, closer, cs_occ;
    logic [RANGE_BITS:0]   dyn_m_sum, nxt_m_sum;
    logic [IDX_W-1:0]      h_start_add, t_start_add;
    logic [CNT_W-1:0]      h_count_add, t_count_add;
    logic [CNT_W:0]        wrap_sum;
    logic [IDX_W-1:0]      h_start_next, h_end_next, t_start_next;
    logic [CNT_W-1:0]      h_count_next, t_count_next;
    logic                  h_fin_next, h_occ_next, sof_next;
    logic                  e0_v, e1_v;
    lsbc_res_t             e0, e1;
    logic [RES_PTR_W-1:0]  e1_slot;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
    endfunction

    function automatic lsbc_res_t mk_res(input logic [IDX_W-1:0] s,
                                         input logic [IDX_W-1:0] e,
                                         input logic [CNT_W-1:0] c, input logic o);
        lsbc_res_t r;
        r.start_idx = 11'(s);
        r.end_idx   = 11'(e);
        r.count     = c;
        r.occ       = o;
        mk_res      = r;
    endfunction

    // Write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_factor_reg <= RF_W'(23170);
            cos_step_reg     <= COS_W'(65535);
            noise_margin_reg <= MARGIN_W'(30);
            occ_margin_reg   <= MARGIN_W'(100);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RANGE_FACTOR:     range_factor_reg <= cfg_data[RF_W-1:0];
                REG_COS_STEP:         cos_step_reg     <= cfg_data[COS_W-1:0];
                REG_NOISE_MARGIN:     noise_margin_reg <= cfg_data[MARGIN_W-1:0];
                REG_OCCLUSION_MARGIN: occ_margin_reg   <= cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Next point of the pair: the word itself, or the first point on wrap
    assign nxt_dyn = sel_wrap_reg ? first_dyn_reg : cur_dyn_reg;
    assign nxt_raw = sel_wrap_reg ? first_raw_reg : cur_raw_reg;

    // Select multiplier operands, current range a and next range b
    assign dh = d_reg[32:16];
    assign dl = d_reg[15:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            MUL_AA:  begin mul_a = MUL_A_W'(prev_dyn_reg); mul_b = MUL_B_W'(prev_dyn_reg); end
            MUL_BB:  begin mul_a = MUL_A_W'(nxt_dyn);      mul_b = MUL_B_W'(nxt_dyn);      end
            MUL_AB:  begin mul_a = MUL_A_W'(prev_dyn_reg); mul_b = MUL_B_W'(nxt_dyn);      end
            MUL_ABC: begin mul_a = prod_reg[31:0];         mul_b = MUL_B_W'(cos_step_reg); end
            MUL_AR:  begin mul_a = MUL_A_W'(prev_dyn_reg); mul_b = range_factor_reg;       end
            MUL_DHH: begin mul_a = MUL_A_W'(dh);           mul_b = MUL_B_W'(dh);           end
            MUL_DHL: begin mul_a = MUL_A_W'(dh);           mul_b = MUL_B_W'(dl);           end
            MUL_DLL: begin mul_a = MUL_A_W'(dl);           mul_b = MUL_B_W'(dl);           end
            default: begin mul_a = '0;                     mul_b = '0;                     end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign s_val = {1'b0, sum_reg, 16'b0};
    assign p_val = {prod_reg[48:0], 1'b0};

    // Advance the breakpoint sequence: dist2 * 2^16 against dmax squared
    always_ff @(posedge aclk) begin
        unique case (cmd.mul_op)
            MUL_AA, MUL_ABC, MUL_DHH: prod_reg <= mul_p;
            MUL_BB: begin
                prod_reg <= mul_p;
                sum_reg  <= {1'b0, prod_reg[31:0]};
            end
            MUL_AB: begin
                prod_reg <= mul_p;
                sum_reg  <= sum_reg + {1'b0, prod_reg[31:0]};
            end
            MUL_AR: begin
                prod_reg <= mul_p;
                d2_reg   <= (s_val > p_val) ? s_val - p_val : '0;
            end
            MUL_D: begin
                d_reg   <= {1'b0, prod_reg[37:0]} + {7'b0, noise_margin_reg, 16'b0};
                big_reg <= 1'b0;
            end
            MUL_DHL: begin
                prod_reg <= mul_p;
                q_reg    <= {1'b0, prod_reg[33:0], 32'b0};
                big_reg  <= |d_reg[38:33];
            end
            MUL_DLL: begin
                prod_reg <= mul_p;
                q_reg    <= q_reg + {17'b0, prod_reg[32:0], 17'b0};
            end
            MUL_SUM: q_reg <= q_reg + {35'b0, prod_reg[31:0]};
            MUL_CMP: within_reg <= big_reg || ({1'b0, d2_reg, 16'b0} < q_reg);
            default: ;
        endcase
    end

    // Judge the pair and build cluster updates
    always_comb begin
        cs          = (prev_dyn_reg == '0);
        ns          = (nxt_dyn == '0);
        dyn_m_sum   = {1'b0, prev_dyn_reg} + {1'b0, occ_margin_reg};
        nxt_m_sum   = {1'b0, nxt_dyn} + {1'b0, occ_margin_reg};
        far         = {1'b0, nxt_raw} > dyn_m_sum;
        closer      = nxt_m_sum > {1'b0, prev_dyn_reg};
        cs_occ      = nxt_m_sum > {1'b0, prev_raw_reg};
        h_start_add = (h_count_reg == '0) ? prev_idx_reg : h_start_reg;
        h_count_add = sat_inc(h_count_reg);
        t_start_add = (t_count_reg == '0) ? prev_idx_reg : t_start_reg;
        t_count_add = sat_inc(t_count_reg);
        wrap_sum    = {1'b0, t_count_add} + {1'b0, h_count_reg};

        h_start_next = h_start_reg;
        h_end_next   = h_end_reg;
        h_count_next = h_count_reg;
        h_fin_next   = h_fin_reg;
        h_occ_next   = h_occ_reg;
        t_start_next = t_start_reg;
        t_count_next = t_count_reg;
        sof_next     = sof_reg;
        e0_v         = 1'b0;
        e1_v         = 1'b0;
        e0           = '0;
        e1           = '0;

        priority if (cs && ns) begin
            if (!h_fin_reg && !pair_seen_reg && !sel_wrap_reg) h_fin_next = 1'b1;
        end else if (ns) begin
            if (!h_fin_reg) begin
                h_start_next = h_start_add;
                h_end_next   = prev_idx_reg;
                h_count_next = h_count_add;
                h_fin_next   = 1'b1;
                h_occ_next   = !far;
                sof_next     = far;
            end else if (t_count_reg != '0) begin
                e0_v         = 1'b1;
                e0           = mk_res(t_start_add, prev_idx_reg, t_count_add, sof_reg || !far);
                t_count_next = '0;
            end
        end else if (cs) begin
            sof_next = cs_occ;
            if (sel_wrap_reg && h_count_reg > CNT_W'(1)) begin
                e0_v = 1'b1;
                e0   = mk_res(h_start_reg, h_end_reg, h_count_reg, cs_occ || h_occ_reg);
            end
        end else if (within_reg) begin
            if (!h_fin_reg) begin
                h_start_next = h_start_add;
                h_end_next   = prev_idx_reg;
                h_count_next = h_count_add;
            end else begin
                t_start_next = t_start_add;
                t_count_next = t_count_add;
                if (sel_wrap_reg) begin
                    e0_v = 1'b1;
                    if (h_count_reg != '0) begin
                        e0 = mk_res(t_start_add, h_end_reg,
                                    wrap_sum[CNT_W] ? COUNT_MAX : wrap_sum[CNT_W-1:0],
                                    sof_reg || h_occ_reg);
                    end else begin
                        e0 = mk_res(t_start_add, prev_idx_reg, t_count_add,
                                    sof_reg || h_occ_reg);
                    end
                end
            end
        end else begin
            if (!h_fin_reg) begin
                h_start_next = h_start_add;
                h_end_next   = prev_idx_reg;
                h_count_next = h_count_add;
                h_fin_next   = 1'b1;
                h_occ_next   = !closer;
                sof_next     = closer;
            end else begin
                if (t_count_reg != '0) begin
                    e0_v         = 1'b1;
                    e0           = mk_res(t_start_add, prev_idx_reg, t_count_add,
                                          sof_reg || !closer);
                    t_count_next = '0;
                end
                sof_next = closer;
                if (sel_wrap_reg && h_count_reg > CNT_W'(1)) begin
                    e1_v = 1'b1;
                    e1   = mk_res(h_start_reg, h_end_reg, h_count_reg, closer || h_occ_reg);
                end
            end
        end
    end

    assign e1_slot = res_cnt_reg + RES_PTR_W'(e0_v);

    // Scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg <= '0;
            have_valid_reg   <= 1'b0;
            pair_seen_reg    <= 1'b0;
            sel_wrap_reg     <= 1'b0;
            sof_reg          <= 1'b0;
            prev_dyn_reg     <= '0;
            prev_raw_reg     <= '0;
            prev_idx_reg     <= '0;
            first_dyn_reg    <= '0;
            first_raw_reg    <= '0;
            h_start_reg      <= '0;
            h_end_reg        <= '0;
            h_count_reg      <= '0;
            h_fin_reg        <= 1'b0;
            h_occ_reg        <= 1'b0;
            t_start_reg      <= '0;
            t_count_reg      <= '0;
        end else begin
            if (cmd.load) sel_wrap_reg <= 1'b0;
            if (cmd.sel_wrap) sel_wrap_reg <= 1'b1;
            if (cmd.init_pt) begin
                first_dyn_reg  <= cur_dyn_reg;
                first_raw_reg  <= cur_raw_reg;
                prev_dyn_reg   <= cur_dyn_reg;
                prev_raw_reg   <= cur_raw_reg;
                prev_idx_reg   <= cur_idx_reg;
                have_valid_reg <= 1'b1;
                pair_seen_reg  <= 1'b0;
            end
            if (cmd.apply) begin
                h_start_reg <= h_start_next;
                h_end_reg   <= h_end_next;
                h_count_reg <= h_count_next;
                h_fin_reg   <= h_fin_next;
                h_occ_reg   <= h_occ_next;
                t_start_reg <= t_start_next;
                t_count_reg <= t_count_next;
                sof_reg     <= sof_next;
                if (!sel_wrap_reg) begin
                    prev_dyn_reg  <= cur_dyn_reg;
                    prev_raw_reg  <= cur_raw_reg;
                    prev_idx_reg  <= cur_idx_reg;
                    pair_seen_reg <= 1'b1;
                end
            end
            // Close the scan on its last word, else step the index, wrapping to zero after the last index
            if (cmd.finish) begin
                if (cur_last_reg) begin
                    sample_index_reg <= '0;
                    have_valid_reg   <= 1'b0;
                    pair_seen_reg    <= 1'b0;
                    sof_reg          <= 1'b0;
                    prev_dyn_reg     <= '0;
                    prev_raw_reg     <= '0;
                    prev_idx_reg     <= '0;
                    first_dyn_reg    <= '0;
                    first_raw_reg    <= '0;
                    h_start_reg      <= '0;
                    h_end_reg        <= '0;
                    h_count_reg      <= '0;
                    h_fin_reg        <= 1'b0;
                    h_occ_reg        <= 1'b0;
                    t_start_reg      <= '0;
                    t_count_reg      <= '0;
                end else if (sample_index_reg == IDX_W'(SCAN_POINTS - 1)) begin
                    sample_index_reg <= '0;
                end else begin
                    sample_index_reg <= sample_index_reg + 1'b1;
                end
            end
        end
    end

    // Capture the incoming word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_dyn_reg  <= in_dyn;
            cur_raw_reg  <= in_raw;
            cur_last_reg <= in_last;
            cur_idx_reg  <= sample_index_reg;
        end
    end

    // Result buffer pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= '0;
            res_rd_reg  <= '0;
        end else if (cmd.apply) begin
            res_cnt_reg <= res_cnt_reg + RES_PTR_W'(e0_v) + RES_PTR_W'(e1_v);
        end else if (cmd.pop) begin
            if (res_rd_reg == res_cnt_reg - 1'b1) begin
                res_rd_reg  <= '0;
                res_cnt_reg <= '0;
            end else begin
                res_rd_reg <= res_rd_reg + 1'b1;
            end
        end
    end

    // Result buffer entries
    always_ff @(posedge aclk) begin
        for (int i = 0; i < RES_DEPTH; i++) begin
            if (cmd.apply && e0_v && res_cnt_reg == RES_PTR_W'(i)) res_reg[i] <= e0;
            if (cmd.apply && e1_v && e1_slot == RES_PTR_W'(i)) res_reg[i] <= e1;
        end
    end

    assign out_res = res_reg[res_rd_reg];

    always_comb begin
        status.pt_valid   = (cur_raw_reg != '0);
        status.have_valid = have_valid_reg;
        status.pair_seen  = pair_seen_reg;
        status.last       = cur_last_reg;
        status.dyn_pair0  = (prev_dyn_reg != '0) && (cur_dyn_reg != '0);
        status.dyn_wrap   = (prev_dyn_reg != '0) && (first_dyn_reg != '0);
        status.sel_wrap   = sel_wrap_reg;
        status.res_any    = (res_cnt_reg != '0);
        status.out_last   = (res_rd_reg == res_cnt_reg - 1'b1);
    end

endmodule

/* hw/rtl/laser_scan_breakpoint_clusterer_core.sv */
// ----------------------------------------------------------------------------
// laser_scan_breakpoint_clusterer_core: laser scan breakpoint clusterer
// Splits a scan into clusters with an adaptive breakpoint test and occlusion
// margins, and emits start, end, count and occluded descriptors.
// ----------------------------------------------------------------------------
//  channel   | direction | carries
//  s_axis_*  | in        | one scan point per word, tlast on the last point
//  m_axis_*  | out       | one cluster descriptor per word, tlast on the last
//  cfg_*     | in        | register index and write data
//
// A point passes the check, an adaptive breakpoint test when it needs one,
// a pair update when it closes a pair, the wrap check and the finish step;
// the test runs on the one shared 32x22 multiplier. The last point may add
// a wrap pair, with a test of its own when needed. Result words are held
// through output stalls. One point is in work at a time; s_axis_tready is
// high only while idle. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module laser_scan_breakpoint_clusterer_core import lsbc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // dynamic_range, raw_range
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // cluster_start, cluster_end,
                                                  // point_count, zero fill
    output logic                  m_axis_tuser,   // occluded
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lsbc_cmd_t    cmd;
    lsbc_status_t status;
    lsbc_res_t    out_res;

    assign cfg_ready = 1'b1;

    lsbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    lsbc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_dyn    (s_axis_tdata[15:0]),
        .in_raw    (s_axis_tdata[31:16]),
        .in_last   (s_axis_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_res   (out_res)
    );

    // Pack the result word
    assign m_axis_tdata = {6'b0, out_res.count, out_res.end_idx, out_res.start_idx};
    assign m_axis_tuser = out_res.occ;
    assign m_axis_tlast = status.out_last;

endmodule
